[sv/tdr_pkg.sv]
// tdr_pkg: shared constants, codes, types and the linear-step function
// of the trilinear dose resampler. No dependencies.
package tdr_pkg;

  localparam int MAX_ROWS_DEF  = 512;
  localparam int MAX_COLS_DEF  = 512;
  localparam int FRAC_BITS_DEF = 16;

  // grid dimension width: holds MAX_ROWS / MAX_COLS up to 8191
  localparam int DIM_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int SAMPLE_W  = 32;

  localparam logic [1:0] OP_LOAD_FRONT = 2'd0;
  localparam logic [1:0] OP_LOAD_BACK  = 2'd1;
  localparam logic [1:0] OP_INTERP     = 2'd2;
  localparam logic [1:0] OP_EMPTY      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROWS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COLS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;

  // control carried alongside the corner reads
  typedef struct packed {
    logic [15:0] frac_row;
    logic [15:0] frac_col;
    logic [16:0] frac_plane;
    logic [3:0]  corner_ok;  // (r,c) (r+1,c) (r,c+1) (r+1,c+1)
    logic        empty;
  } tdr_item_t;

  // a*(1-f) + b*f with f in 1.16 (0 to 1.0), exact
  function automatic logic [64:0] lerp(input logic [47:0] a, input logic [47:0] b,
                                       input logic [16:0] f);
    logic [16:0] g;
    logic [64:0] pa;
    logic [64:0] pb;
    g  = 17'h10000 - f;
    pa = a * g;
    pb = b * f;
    return pa + pb;
  endfunction

endpackage

[sv/tdr_ram.sv]
// tdr_ram: generic single-write, single-read synchronous RAM,
// registered read with read enable. No dependencies.
module tdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/tdr_lerp_pipe.sv]
// tdr_lerp_pipe: arithmetic pipeline from corner reads to the output
// register (row, column, plane steps, scaling, saturation). Uses tdr_pkg.
module tdr_lerp_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  tdr_pkg::tdr_item_t  s1_item,
  input  logic [3:0][31:0]    front_rd,
  input  logic [3:0][31:0]    back_rd,
  input  logic                source_wide,
  input  logic                output_wide,
  input  logic [31:0]         scale_factor,
  output logic                adv2,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,   // dose_value
  output logic [0:0]          out_tuser    // clipped
);
  import tdr_pkg::*;

  logic en_o, en6, en5, en4, en3, en2;
  logic v2_r, v3_r, v4_r, v5_r, v6_r, ov_r;
  tdr_item_t it2_r;

  logic [47:0] fl_r, fr_r, bl_r, br_r;
  logic [15:0] fc3_r;
  logic [16:0] fp3_r, fp4_r;
  logic        e3_r, e4_r, e5_r, e6_r;
  logic [47:0] front4_r, back4_r;
  logic [47:0] v5_val_r;
  logic [63:0] a6_r;
  logic [48:0] b6_r;
  logic [31:0] dose_r;
  logic        clip_r;

  logic [3:0][47:0] fc_w, bc_w;
  logic [64:0] l_fl, l_fr, l_bl, l_br, l_front, l_back, l_plane;
  logic [49:0] low_w;
  logic [48:0] res_w;
  logic [31:0] limit_w;

  assign en_o = !ov_r || out_tready;
  assign en6  = !v6_r || en_o;
  assign en5  = !v5_r || en6;
  assign en4  = !v4_r || en5;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign adv2 = en2;

  // corner masking: outside the grid reads zero, narrow samples keep low half
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fc_w[k] = '0;
      bc_w[k] = '0;
      if (it2_r.corner_ok[k]) begin
        fc_w[k] = source_wide ? 48'(front_rd[k]) : 48'(front_rd[k][15:0]);
        bc_w[k] = source_wide ? 48'(back_rd[k]) : 48'(back_rd[k][15:0]);
      end
    end
  end

  assign l_fl = lerp(fc_w[0], fc_w[1], {1'b0, it2_r.frac_row});
  assign l_fr = lerp(fc_w[2], fc_w[3], {1'b0, it2_r.frac_row});
  assign l_bl = lerp(bc_w[0], bc_w[1], {1'b0, it2_r.frac_row});
  assign l_br = lerp(bc_w[2], bc_w[3], {1'b0, it2_r.frac_row});

  assign l_front = lerp(fl_r, fr_r, {1'b0, fc3_r}) + 65'h8000;
  assign l_back  = lerp(bl_r, br_r, {1'b0, fc3_r}) + 65'h8000;
  assign l_plane = lerp(front4_r, back4_r, fp4_r) + 65'h8000;

  assign low_w   = 50'({a6_r[15:0], 16'h0000}) + 50'(b6_r);
  assign res_w   = 49'(a6_r[63:16]) + 49'(low_w[49:32]);
  assign limit_w = output_wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en2) v2_r <= s1_valid;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en_o) ov_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      it2_r <= s1_item;
    end
    if (en3) begin
      fl_r  <= l_fl[47:0];
      fr_r  <= l_fr[47:0];
      bl_r  <= l_bl[47:0];
      br_r  <= l_br[47:0];
      fc3_r <= it2_r.frac_col;
      fp3_r <= it2_r.frac_plane;
      e3_r  <= it2_r.empty;
    end
    if (en4) begin
      front4_r <= l_front[63:16];
      back4_r  <= l_back[63:16];
      fp4_r    <= fp3_r;
      e4_r     <= e3_r;
    end
    if (en5) begin
      v5_val_r <= l_plane[63:16];
      e5_r     <= e4_r;
    end
    if (en6) begin
      a6_r <= v5_val_r[47:16] * scale_factor;
      b6_r <= 49'(v5_val_r[15:0] * scale_factor) + 49'h0_8000_0000;
      e6_r <= e5_r;
    end
    if (en_o) begin
      if (e6_r) begin
        dose_r <= '0;
        clip_r <= 1'b0;
      end else if (res_w > 49'(limit_w)) begin
        dose_r <= limit_w;
        clip_r <= 1'b1;
      end else begin
        dose_r <= res_w[31:0];
        clip_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = dose_r;
  assign out_tuser  = clip_r;

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && clip_r |-> dose_r == limit_w)
    else $error("clipped result not at limit");

  a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !output_wide |-> dose_r <= 32'h0000_FFFF)
    else $error("narrow result above 16 bits");

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !en3 |=> v2_r)
    else $error("corner stage lost an item while stalled");

endmodule

[sv/trilinear_dose_resampler.sv]
// trilinear_dose_resampler: top level. Takes beats, holds configuration,
// forms corner addresses and owns the plane stores. Uses tdr_pkg, tdr_ram,
// tdr_lerp_pipe.
//
// One beat per clock is taken and one result per clock given when the
// output side keeps up; an interpolate or empty beat gives a result, load
// beats give none. The rate is set by the stores: each plane is held in
// four identical RAM copies, each written by every load and read at one
// corner, so all eight corners of a voxel are read in one cycle. Loads
// and reads both happen in the address stage in arrival order, so a load
// is always seen by any later read. The stores need no clearing pass
// after reset; reading a never-loaded sample is not supported. The user must
// write configuration only while idle; the block does not enforce it.
module trilinear_dose_resampler #(
  parameter int MAX_ROWS  = tdr_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = tdr_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = tdr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // operation[1:0] sample_address[19:2] sample_value[51:20]
  // row_position[83:52] col_position[115:84] plane_fraction[132:116]
  input  logic [135:0]                  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,   // dose_value[31:0]
  output logic [0:0]                    out_tuser,   // clipped[0]
  input  logic                          cfg_we,
  input  logic [tdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tdr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import tdr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int PW    = RB + DIM_W;

  // configuration
  logic [9:0]  src_rows_r, src_cols_r;
  logic        src_wide_r, out_wide_r;
  logic [31:0] scale_r;
  logic [DIM_W-1:0] rows_eff, cols_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= 10'd512;
      src_cols_r <= 10'd512;
      src_wide_r <= 1'b0;
      out_wide_r <= 1'b0;
      scale_r    <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_ROWS:  src_rows_r <= cfg_wdata[9:0];
        REG_SOURCE_COLS:  src_cols_r <= cfg_wdata[9:0];
        REG_SOURCE_WIDE:  src_wide_r <= cfg_wdata[0];
        REG_OUTPUT_WIDE:  out_wide_r <= cfg_wdata[0];
        REG_SCALE_FACTOR: scale_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grid clipped to the store size
  assign rows_eff = (DIM_W'(src_rows_r) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                            : DIM_W'(src_rows_r);
  assign cols_eff = (DIM_W'(src_cols_r) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                            : DIM_W'(src_cols_r);

  // input field split
  logic [1:0]  in_op;
  logic [17:0] in_addr;
  logic [31:0] in_sample, in_rowp, in_colp;
  logic [16:0] in_fp;

  assign in_op     = in_tdata[1:0];
  assign in_addr   = in_tdata[19:2];
  assign in_sample = in_tdata[51:20];
  assign in_rowp   = in_tdata[83:52];
  assign in_colp   = in_tdata[115:84];
  assign in_fp     = in_tdata[132:116];

  // floor, fractions and corner bounds, before the address stage
  logic signed [33:0] r_s, c_s, r1_s, c1_s;
  logic [47:0]        fr_x, fc_x;
  logic               rv0, rv1, cv0, cv1, load_ok;
  tdr_item_t          item_in;

  always_comb begin
    r_s  = 34'($signed(in_rowp) >>> FRAC_BITS);
    c_s  = 34'($signed(in_colp) >>> FRAC_BITS);
    r1_s = r_s + 34'sd1;
    c1_s = c_s + 34'sd1;
    rv0  = (r_s >= 0) && (r_s < $signed(34'(rows_eff)));
    rv1  = (r1_s >= 0) && (r1_s < $signed(34'(rows_eff)));
    cv0  = (c_s >= 0) && (c_s < $signed(34'(cols_eff)));
    cv1  = (c1_s >= 0) && (c1_s < $signed(34'(cols_eff)));
    fr_x = ({16'h0000, in_rowp} << 16) >> FRAC_BITS;
    fc_x = ({16'h0000, in_colp} << 16) >> FRAC_BITS;
    item_in.frac_row   = fr_x[15:0];
    item_in.frac_col   = fc_x[15:0];
    item_in.frac_plane = (in_fp > 17'h10000) ? 17'h10000 : in_fp;
    item_in.corner_ok  = {rv1 & cv1, rv0 & cv1, rv1 & cv0, rv0 & cv0};
    item_in.empty      = (in_op == OP_EMPTY);
    load_ok = 32'(in_addr) < 32'(DEPTH);
  end

  // address stage
  logic            v1_r, lok1_r;
  logic [1:0]      op1_r;
  logic [17:0]     addr1_r;
  logic [31:0]     sample1_r;
  logic [RB-1:0]   ridx1_r, r1idx1_r;
  logic [CB-1:0]   cidx1_r, c1idx1_r;
  tdr_item_t       item1_r;

  logic            s1_load, s1_leave, adv2;
  logic [31:0]     waddr_x;
  logic [PW-1:0]   prod0, prod1;
  logic [3:0][AW-1:0] raddr;
  logic            we_front, we_back;
  logic [3:0][31:0] front_rd, back_rd;

  assign s1_load   = (op1_r == OP_LOAD_FRONT) || (op1_r == OP_LOAD_BACK);
  assign s1_leave  = v1_r && (s1_load || adv2);
  assign in_tready = !v1_r || s1_leave;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      op1_r     <= in_op;
      addr1_r   <= in_addr;
      sample1_r <= in_sample;
      lok1_r    <= load_ok;
      ridx1_r   <= r_s[RB-1:0];
      r1idx1_r  <= r1_s[RB-1:0];
      cidx1_r   <= c_s[CB-1:0];
      c1idx1_r  <= c1_s[CB-1:0];
      item1_r   <= item_in;
    end
  end

  // corner addresses: each row and column index on its own, so a corner
  // next to one off the grid still lands on the right word
  always_comb begin
    prod0 = ridx1_r * cols_eff;
    prod1 = r1idx1_r * cols_eff;
    raddr[0] = AW'(prod0 + PW'(cidx1_r));
    raddr[1] = AW'(prod1 + PW'(cidx1_r));
    raddr[2] = AW'(prod0 + PW'(c1idx1_r));
    raddr[3] = AW'(prod1 + PW'(c1idx1_r));
    waddr_x  = 32'(addr1_r);
  end

  assign we_front = v1_r && lok1_r && (op1_r == OP_LOAD_FRONT);
  assign we_back  = v1_r && lok1_r && (op1_r == OP_LOAD_BACK);

  for (genvar k = 0; k < 4; k++) begin : g_copy
    tdr_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_front (
      .clk   (clk),
      .we    (we_front),
      .waddr (waddr_x[AW-1:0]),
      .wdata (sample1_r),
      .re    (adv2),
      .raddr (raddr[k]),
      .rdata (front_rd[k])
    );
    tdr_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_back (
      .clk   (clk),
      .we    (we_back),
      .waddr (waddr_x[AW-1:0]),
      .wdata (sample1_r),
      .re    (adv2),
      .raddr (raddr[k]),
      .rdata (back_rd[k])
    );
  end

  tdr_lerp_pipe u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (v1_r && !s1_load),
    .s1_item      (item1_r),
    .front_rd     (front_rd),
    .back_rd      (back_rd),
    .source_wide  (src_wide_r),
    .output_wide  (out_wide_r),
    .scale_factor (scale_r),
    .adv2         (adv2),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

  a_one_plane_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_front && we_back))
    else $error("both planes written in one cycle");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("address stage empty but input not ready");

  a_load_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && s1_load |-> in_tready)
    else $error("load beat stalled in address stage");

endmodule
